### rtl/core/nlsc_pkg.sv
// Shared types and constants for the notch and LMS sinusoid canceller.
// Used by the sequencer, the datapath, the sine table, the top level and the testbench; no dependencies.

package nlsc_pkg;

  // Fixed field and register widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned TRIG_W   = 17;   // Q1.15 table value, -32768..32768

  // Shared multiplier and internal word widths.
  localparam int unsigned OPA_W   = 34;
  localparam int unsigned OPB_W   = 17;
  localparam int unsigned PROD_W  = OPA_W + OPB_W;
  localparam int unsigned ACC_W   = 49;    // error in Q.44
  localparam int unsigned ERR_W   = 34;    // error in Q.29
  localparam int unsigned GAIN_W  = 26;    // mu * error in Q.29
  localparam int unsigned DELTA_W = 27;    // weight increment

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NOTCH_COSINE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 2'd2;

  localparam logic signed [CFG_W-1:0] NOTCH_COSINE_RST = 16'sd16384;
  localparam logic [CFG_W-1:0]        PHASE_STEP_RST   = 16'd0;
  localparam logic [CFG_W-1:0]        STEP_SIZE_RST    = 16'd1359;

  // Operand pairs of the shared multiplier.
  typedef enum logic [2:0] {
    OP_NOTCH,      // notch_cosine * x[n-1]
    OP_COS_W,      // cosine weight * cos
    OP_SIN_W,      // sine weight * sin
    OP_GAIN,       // error * step size
    OP_UPD_COS,    // gain * cos
    OP_UPD_SIN     // gain * sin
  } op_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NOTCH,
    ST_COS,
    ST_SIN,
    ST_EST,
    ST_ERR,
    ST_GAIN,
    ST_GRND,
    ST_UPC,
    ST_UPS,
    ST_FIN
  } state_e;

  typedef struct packed {
    op_sel_e op;
    logic    load_x;
    logic    acc_init;
    logic    acc_sub;
    logic    load_err;
    logic    load_out;
    logic    load_g;
    logic    upd_a;
    logic    upd_b;
    logic    finish;
  } ctl_t;

endpackage

### rtl/core/notch_lms_sinusoid_canceller.sv
// A result is registered at the end of the gain step. A new sample is taken
// only in idle, once the previous sample's weight and phase update is done;
// the single 34x17 multiplier computes the six products of a sample in turn.
// A stalled output holds the sequencer in its gain step until it is taken.
// Reset (asynchronous, active low) clears the delay line, weights and phase
// and loads the register defaults; the block is ready in the first cycle.

module notch_lms_sinusoid_canceller
  import nlsc_pkg::*;
#(
  parameter int unsigned PHASE_BITS       = 16,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // [15:0] sample_in
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // [15:0] sample_out
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic signed [CFG_W-1:0] notch_cosine_q;
  logic [CFG_W-1:0]        phase_step_q;
  logic [CFG_W-1:0]        step_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      notch_cosine_q <= NOTCH_COSINE_RST;
      phase_step_q   <= PHASE_STEP_RST;
      step_size_q    <= STEP_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_NOTCH_COSINE: notch_cosine_q <= $signed(cfg_wdata_i);
        REG_PHASE_STEP:   phase_step_q   <= cfg_wdata_i;
        REG_STEP_SIZE:    step_size_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ctl_t                                ctl;
  logic [$clog2(SINE_TABLE_DEPTH)-1:0] rom_addr;
  logic signed [TRIG_W-1:0]            sin_val;
  logic signed [TRIG_W-1:0]            cos_val;
  logic signed [SAMPLE_W-1:0]          sample_out;

  nlsc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .ctl_o         (ctl)
  );

  nlsc_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .sin_o  (sin_val),
    .cos_o  (cos_val)
  );

  nlsc_datapath #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sample_in_i    ($signed(s_axis_tdata)),
    .notch_cosine_i (notch_cosine_q),
    .phase_step_i   (phase_step_q),
    .step_size_i    (step_size_q),
    .sin_i          (sin_val),
    .cos_i          (cos_val),
    .rom_addr_o     (rom_addr),
    .sample_out_o   (sample_out)
  );

  assign m_axis_tdata = sample_out;

endmodule

### rtl/core/nlsc_sine_rom.sv
// Sine and cosine table with a registered read port.
// Entries are the quarter-wave polynomial, built at elaboration; uses nlsc_pkg.

module nlsc_sine_rom
  import nlsc_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                               clk_i,
  input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr_i,
  output logic signed [TRIG_W-1:0]           sin_o,
  output logic signed [TRIG_W-1:0]           cos_o
);

  localparam logic [63:0] PolyA = 64'd102944;
  localparam logic [63:0] PolyB = 64'd42047;
  localparam logic [63:0] PolyC = 64'd4640;

  // Sine of a 16-bit fraction of a full circle, Q1.15.
  function automatic logic signed [TRIG_W-1:0] poly_sine(input logic [15:0] turn);
    logic [1:0]  quad;
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] inner;
    logic [63:0] mid;
    logic [63:0] s;
    quad  = turn[15:14];
    t     = quad[0] ? (64'd16384 - 64'(turn[13:0])) : 64'(turn[13:0]);
    x     = t << 2;
    x2    = (x * x) >> 16;
    inner = PolyB - ((x2 * PolyC) >> 16);
    mid   = PolyA - ((x2 * inner) >> 16);
    s     = (x * mid) >> 17;
    return quad[1] ? -$signed(TRIG_W'(s)) : $signed(TRIG_W'(s));
  endfunction

  logic signed [TRIG_W-1:0] sin_tab [SINE_TABLE_DEPTH];
  logic signed [TRIG_W-1:0] cos_tab [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_tab
    localparam int unsigned Turn = (k * 65536) / SINE_TABLE_DEPTH;
    assign sin_tab[k] = poly_sine(16'(Turn));
    assign cos_tab[k] = poly_sine(16'(Turn + 16384));
  end

  always_ff @(posedge clk_i) begin
    sin_o <= sin_tab[addr_i];
    cos_o <= cos_tab[addr_i];
  end

endmodule

### rtl/core/nlsc_datapath.sv
// Datapath: notch delay line, shared 34x17 multiplier, error accumulator,
// LMS weights and phase accumulator. Uses nlsc_pkg; driven by nlsc_ctrl.

module nlsc_datapath
  import nlsc_pkg::*;
#(
  parameter int unsigned PHASE_BITS       = 16,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ctl_t                                ctl_i,
  input  logic signed [SAMPLE_W-1:0]          sample_in_i,
  input  logic signed [CFG_W-1:0]             notch_cosine_i,
  input  logic [CFG_W-1:0]                    phase_step_i,
  input  logic [CFG_W-1:0]                    step_size_i,
  input  logic signed [TRIG_W-1:0]            sin_i,
  input  logic signed [TRIG_W-1:0]            cos_i,
  output logic [$clog2(SINE_TABLE_DEPTH)-1:0] rom_addr_o,
  output logic signed [SAMPLE_W-1:0]          sample_out_o
);

  localparam int unsigned AddrW = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned DepW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned IdxW  = PHASE_BITS + DepW;
  localparam int unsigned OutW  = ERR_W - 14;

  function automatic logic signed [WEIGHT_W-1:0] sat_w(input logic signed [WEIGHT_W+1:0] v);
    logic signed [WEIGHT_W+1:0] hi;
    logic signed [WEIGHT_W+1:0] lo;
    hi = (WEIGHT_W+2)'({1'b0, {(WEIGHT_W-1){1'b1}}});
    lo = -hi - (WEIGHT_W+2)'(1);
    if (v > hi) return hi[WEIGHT_W-1:0];
    if (v < lo) return lo[WEIGHT_W-1:0];
    return v[WEIGHT_W-1:0];
  endfunction

  logic signed [SAMPLE_W-1:0]  x_q, d1_q, d2_q;
  logic signed [WEIGHT_W-1:0]  a_q, b_q;
  logic [PHASE_BITS-1:0]       phase_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]     acc_q, acc_d;
  logic signed [ERR_W-1:0]     err_q;
  logic signed [GAIN_W-1:0]    g_q;
  logic signed [SAMPLE_W-1:0]  out_q;

  logic signed [OPA_W-1:0]     op_a;
  logic signed [OPB_W-1:0]     op_b;
  logic signed [SAMPLE_W:0]    xsum;
  logic signed [ACC_W-1:0]     acc_rnd;
  logic signed [ERR_W-1:0]     err_rnd;
  logic signed [OutW-1:0]      out_wide;
  logic signed [SAMPLE_W-1:0]  out_sat;
  logic signed [PROD_W-1:0]    prod_g_rnd;
  logic signed [PROD_W-1:0]    prod_d_rnd;
  logic signed [DELTA_W-1:0]   delta;
  logic [IdxW-1:0]             idx_full;

  // Table index: floor(phase * depth / 2^PHASE_BITS).
  assign idx_full   = IdxW'(phase_q) * IdxW'(SINE_TABLE_DEPTH);
  assign rom_addr_o = idx_full[PHASE_BITS +: AddrW];

  always_comb begin
    unique case (ctl_i.op)
      OP_NOTCH: begin
        op_a = OPA_W'(notch_cosine_i);
        op_b = OPB_W'(d1_q);
      end
      OP_COS_W: begin
        op_a = OPA_W'(a_q);
        op_b = cos_i;
      end
      OP_SIN_W: begin
        op_a = OPA_W'(b_q);
        op_b = sin_i;
      end
      OP_GAIN: begin
        op_a = err_q;
        op_b = $signed({1'b0, step_size_i});
      end
      OP_UPD_COS: begin
        op_a = OPA_W'(g_q);
        op_b = cos_i;
      end
      OP_UPD_SIN: begin
        op_a = OPA_W'(g_q);
        op_b = sin_i;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // The error is built as y*2^15 - a*cos - b*sin, one product per cycle.
  assign xsum = (SAMPLE_W+1)'(x_q) + (SAMPLE_W+1)'(d2_q);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.acc_init) begin
      acc_d = (ACC_W'(xsum) <<< 29) - (ACC_W'(prod_q) <<< 16);
    end else if (ctl_i.acc_sub) begin
      acc_d = acc_q - ACC_W'(prod_q);
    end
  end

  // Round half up on each right shift.
  assign acc_rnd    = acc_q + ACC_W'(1 <<< 14);
  assign err_rnd    = $signed(acc_rnd[ACC_W-1:15]);
  assign out_wide   = OutW'((ERR_W+1)'(err_q) + (ERR_W+1)'(1 <<< 13) >>> 14);
  assign prod_g_rnd = prod_q + PROD_W'(1 <<< 23);
  assign prod_d_rnd = prod_q + PROD_W'(1 <<< 14);
  assign delta      = $signed(prod_d_rnd[15 +: DELTA_W]);

  always_comb begin
    if (out_wide > OutW'(32767)) begin
      out_sat = 16'sh7FFF;
    end else if (out_wide < -OutW'(32768)) begin
      out_sat = -16'sh8000;
    end else begin
      out_sat = out_wide[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    acc_q  <= acc_d;
    if (ctl_i.load_x)   x_q   <= sample_in_i;
    if (ctl_i.load_err) err_q <= err_rnd;
    if (ctl_i.load_g)   g_q   <= $signed(prod_g_rnd[24 +: GAIN_W]);
    if (ctl_i.load_out) out_q <= out_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q    <= '0;
      d2_q    <= '0;
      a_q     <= '0;
      b_q     <= '0;
      phase_q <= '0;
    end else begin
      if (ctl_i.upd_a) a_q <= sat_w((WEIGHT_W+2)'(a_q) + (WEIGHT_W+2)'(delta));
      if (ctl_i.upd_b) b_q <= sat_w((WEIGHT_W+2)'(b_q) + (WEIGHT_W+2)'(delta));
      if (ctl_i.finish) begin
        d2_q    <= d1_q;
        d1_q    <= x_q;
        phase_q <= phase_q + PHASE_BITS'(phase_step_i);
      end
    end
  end

  assign sample_out_o = out_q;

endmodule

### rtl/core/nlsc_ctrl.sv
// Sequencer that steps the shared multiplier through one sample's products
// and owns the stream handshakes. Uses nlsc_pkg; drives nlsc_datapath.

module nlsc_ctrl
  import nlsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output ctl_t ctl_o
);

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin : p_next
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_NOTCH;
      ST_NOTCH: state_d = ST_COS;
      ST_COS:   state_d = ST_SIN;
      ST_SIN:   state_d = ST_EST;
      ST_EST:   state_d = ST_ERR;
      ST_ERR:   state_d = ST_GAIN;
      ST_GAIN:  if (out_free) state_d = ST_GRND;
      ST_GRND:  state_d = ST_UPC;
      ST_UPC:   state_d = ST_UPS;
      ST_UPS:   state_d = ST_FIN;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin : p_out
    ctl_o         = '0;
    ctl_o.op      = OP_NOTCH;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ctl_o.load_x  = s_axis_tvalid;
      end
      ST_NOTCH: ctl_o.op = OP_NOTCH;
      ST_COS: begin
        ctl_o.op       = OP_COS_W;
        ctl_o.acc_init = 1'b1;
      end
      ST_SIN: begin
        ctl_o.op      = OP_SIN_W;
        ctl_o.acc_sub = 1'b1;
      end
      ST_EST:  ctl_o.acc_sub  = 1'b1;
      ST_ERR:  ctl_o.load_err = 1'b1;
      ST_GAIN: begin
        ctl_o.op       = OP_GAIN;
        ctl_o.load_out = out_free;
      end
      ST_GRND: ctl_o.load_g = 1'b1;
      ST_UPC:  ctl_o.op     = OP_UPD_COS;
      ST_UPS: begin
        ctl_o.op    = OP_UPD_SIN;
        ctl_o.upd_a = 1'b1;
      end
      ST_FIN: begin
        ctl_o.upd_b  = 1'b1;
        ctl_o.finish = 1'b1;
      end
      default: ctl_o = '0;
    endcase
  end

  // The output register holds one result until the downstream side takes it.
  always_comb begin
    out_vld_d = out_vld_q;
    if (ctl_o.load_out) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |-> !ctl_o.load_out)
    else $error("result register overwritten before it was taken");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_GAIN))
    else $error("output became valid outside the gain step");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_NOTCH))
    else $error("accepted sample did not start the sequence");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.finish |=> (state_q == ST_IDLE && s_axis_tready))
    else $error("sequencer did not return to idle after the update");

endmodule

### tb/notch_lms_sinusoid_canceller_test.sv
// Self-checking testbench for the notch and LMS sinusoid canceller.
// Depends on nlsc_pkg and notch_lms_sinusoid_canceller; a bit-exact predictor
// of the canceller checks every output sample.
`timescale 1ns / 100ps

module notch_lms_sinusoid_canceller_test;
  import nlsc_pkg::*;

  localparam int unsigned PHASE_BITS       = 16;
  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // decodes to nothing

  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  // Quarter-wave sine polynomial coefficients.
  localparam longint unsigned POLY_A = 102944;
  localparam longint unsigned POLY_B = 42047;
  localparam longint unsigned POLY_C = 4640;

  class canceller_scoreboard;
    int notch_coef;
    int phase_inc;
    int adapt_rate;
    int x_prev1;
    int x_prev2;
    int w_cos;
    int w_sin;
    longint unsigned ref_phase;
    logic [15:0] pending_error_samples[$];
    int mismatches;

    function new();
      notch_coef = NOTCH_COSINE_RST;
      phase_inc  = PHASE_STEP_RST;
      adapt_rate = STEP_SIZE_RST;
      x_prev1    = 0;
      x_prev2    = 0;
      w_cos      = 0;
      w_sin      = 0;
      ref_phase  = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_NOTCH_COSINE: notch_coef = int'($signed(value));
        REG_PHASE_STEP:   phase_inc  = int'(value);
        REG_STEP_SIZE:    adapt_rate = int'(value);
        default: ;
      endcase
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function int clamp_word(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    // Sine of a 16-bit fraction of a circle in Q1.15.
    function longint sine_q15(longint unsigned turn);
      longint unsigned quad, r, t, x, x2, inner, mid;
      longint mag;
      quad  = (turn >> 14) & 3;
      r     = turn & 16'h3fff;
      t     = quad[0] ? 16384 - r : r;
      x     = t << 2;
      x2    = (x * x) >> 16;
      inner = POLY_B - ((x2 * POLY_C) >> 16);
      mid   = POLY_A - ((x2 * inner) >> 16);
      mag   = longint'((x * mid) >> 17);
      return quad[1] ? -mag : mag;
    endfunction

    // Runs one sample through notch, canceller and weight update.
    function void note_sample(logic [15:0] data);
      longint x, y, cs, sn, est, e44, err, o, g;
      longint unsigned idx, turn;
      x = longint'($signed(data));
      y = x * 16384 - 2 * longint'(notch_coef) * longint'(x_prev1)
          + longint'(x_prev2) * 16384;
      x_prev2 = x_prev1;
      x_prev1 = int'(x);

      idx  = (ref_phase * SINE_TABLE_DEPTH) >> PHASE_BITS;
      turn = (idx * 65536) / SINE_TABLE_DEPTH;
      sn   = sine_q15(turn & 16'hffff);
      cs   = sine_q15((turn + 16'h4000) & 16'hffff);

      est = longint'(w_cos) * cs + longint'(w_sin) * sn;
      e44 = y * 32768 - est;
      err = round_shift(e44, 15);
      o   = round_shift(err, 14);
      if (o > 32767) o = 32767;
      if (o < -32768) o = -32768;
      pending_error_samples.push_back(o[15:0]);

      // The update works on the unsaturated error.
      g     = round_shift(err * longint'(adapt_rate), 24);
      w_cos = clamp_word(longint'(w_cos) + round_shift(g * cs, 15));
      w_sin = clamp_word(longint'(w_sin) + round_shift(g * sn, 15));
      ref_phase = (ref_phase + longint'(phase_inc)) & ((64'd1 << PHASE_BITS) - 1);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [15:0] got);
      logic [15:0] want;
      if (pending_error_samples.size() == 0) begin
        report($sformatf("output sample %0d with none outstanding", $signed(got)));
        return;
      end
      want = pending_error_samples.pop_front();
      if (got !== want)
        report($sformatf("sample_out %0d, predicted %0d", $signed(got), $signed(want)));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata;   // [15:0] sample_in
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;   // [15:0] sample_out
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_addr_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  canceller_scoreboard sb;
  bit gaps_on;
  bit ask_long_hold;
  int hold_left;
  int stall_cycles;

  notch_lms_sinusoid_canceller #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (ask_long_hold) begin
      ask_long_hold = 1'b0;
      hold_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with tvalid still high.
  task automatic send_sample(input logic [15:0] value);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= value;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stops the input and lets the block finish its weight and phase update.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_error_samples.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    sb.set_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input int coef, input int step, input int rate);
    drain();
    write_reg(REG_NOTCH_COSINE, 16'(coef));
    write_reg(REG_SPARE, 16'($urandom()));
    write_reg(REG_PHASE_STEP, 16'(step));
    write_reg(REG_STEP_SIZE, 16'(rate));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 7))
      0, 1, 2: return 16'($urandom());
      3, 4:    return 16'($signed($urandom_range(0, 512)) - 256);
      5:       return 16'h7fff;
      6:       return 16'h8000;
      default: return 16'($signed($urandom_range(0, 4096)) + 28000);
    endcase
  endfunction

  function automatic int pick_coef();
    case ($urandom_range(0, 6))
      0: return -16384;
      1: return 16384;
      2: return -32768;
      3: return 32767;
      4: return 0;
      5: return $signed($urandom_range(0, 32768)) - 16384;
      default: return $signed(16'($urandom()));
    endcase
  endfunction

  function automatic int pick_step();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(1, 2000);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 65535;
      2: return STEP_SIZE_RST;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  localparam logic [15:0] RESET_SET_SAMPLES [10] = '{
    16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
    16'h0001, 16'hffff, 16'h5555, 16'haaaa, 16'h0000
  };

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    gaps_on       = 1'b1;
    ask_long_hold = 1'b0;
    hold_left     = 0;
    stall_cycles  = 0;
    sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: register defaults, then out-of-range coefficient with
    // full-scale alternation so that the output saturates.
    foreach (RESET_SET_SAMPLES[i]) send_sample(RESET_SET_SAMPLES[i]);
    apply_setting(-32768, 65535, 65535);
    for (int i = 0; i < 8; i++) send_sample(i[0] ? 16'h8000 : 16'h7fff);
    apply_setting(32767, 1, 0);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'h7fff : 16'h8000);

    // A steady near-full-scale input through the strongest notch at zero
    // phase drives the cosine weight up toward full scale.
    apply_setting(-32768, 0, 65535);
    for (int i = 0; i < 320; i++) send_sample(16'($urandom_range(32000, 32767)));

    for (int ph = 0; ph < 5; ph++) begin
      apply_setting(pick_coef(), pick_step(), pick_rate());
      gaps_on = (ph == 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (ph == 1) ask_long_hold = 1'b1;
      for (int i = 0; i < 52; i++) send_sample(random_sample());
    end

    drain();
    while (sb.pending_error_samples.size() != 0) begin
      sb.report("predicted output sample never arrived");
      void'(sb.pending_error_samples.pop_front());
    end
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### notch_lms_sinusoid_canceller.f
rtl/core/nlsc_pkg.sv
rtl/core/nlsc_sine_rom.sv
rtl/core/nlsc_datapath.sv
rtl/core/nlsc_ctrl.sv
rtl/core/notch_lms_sinusoid_canceller.sv
tb/notch_lms_sinusoid_canceller_test.sv
